>>> sv/usv_pkg.sv
// shared types and constants for the utf-8 stream validator
package usv_pkg;

    // range rule for the first continuation byte after a lead byte
    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_C2   = 3'd1,
        RULE_E0   = 3'd2,
        RULE_ED   = 3'd3,
        RULE_F0   = 3'd4,
        RULE_F4   = 3'd5
    } t_rule;

    // per-string decoder state
    typedef struct packed {
        logic [1:0] pending;
        t_rule      rule;
        logic       err;
    } t_state;

    localparam t_state STATE_CLEAR = '{pending: 2'd0, rule: RULE_NONE, err: 1'b0};

    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DEL     = 8'h7F;
    localparam logic [7:0] BYTE_MAX     = 8'hF4;
    localparam logic [7:0] BYTE_C0      = 8'hC0;
    localparam logic [7:0] BYTE_C1      = 8'hC1;
    localparam logic [7:0] BYTE_C2      = 8'hC2;
    localparam logic [7:0] BYTE_E0      = 8'hE0;
    localparam logic [7:0] BYTE_ED      = 8'hED;
    localparam logic [7:0] BYTE_F0      = 8'hF0;
    localparam logic [7:0] BYTE_F4      = 8'hF4;
    localparam logic [7:0] BYTE_A0      = 8'hA0;
    localparam logic [7:0] BYTE_90      = 8'h90;

endpackage

>>> sv/utf8_stream_validator.sv
// utf8_stream_validator: strict utf-8 checker, top level
//
// Input channel (i_in_valid / o_in_ready) carries one byte of a string per
// item, with i_last_byte on the final item; i_no_byte marks an item that
// carries no byte (used to end a string, or an empty one).
// Output channel (o_out_valid / i_out_ready) carries one verdict per string,
// o_valid_res = 1 when the whole string is well-formed strict utf-8.
// An accepted item sits in the input register and is decoded against the
// state register; a final item's verdict goes on into the output register,
// which drives o_out_valid. One item per cycle sustained, set by the single
// input register feeding the decode logic, unless a final item stalls.
// When the receiver stalls, the verdict holds in the output register while
// byte items keep flowing; only a second final item waits in the input
// register, and o_in_ready drops until the output register frees up.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// string state.
module utf8_stream_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    input  logic       i_no_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_valid_res
);
    import usv_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte_value;
    logic       r_last_byte;
    logic       r_no_byte;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic       r_valid_res;
    logic       n_valid_res;
    logic       out_free;
    logic       fire;
    logic       in_take;

    // handshake control
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!r_last_byte || out_free);
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;

    usv_step u_step (
        .i_state      (r_state),
        .i_byte_value (r_byte_value),
        .i_last_byte  (r_last_byte),
        .i_no_byte    (r_no_byte),
        .o_state      (n_state),
        .o_valid_res  (n_valid_res)
    );

    // input register, string state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (fire && r_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_byte_value <= i_byte_value;
            r_last_byte  <= i_last_byte;
            r_no_byte    <= i_no_byte;
        end
        if (fire && r_last_byte) begin
            r_valid_res <= n_valid_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_valid_res;

endmodule

>>> sv/usv_step.sv
// next-state and verdict logic for one item
module usv_step (
    input  usv_pkg::t_state i_state,
    input  logic [7:0]      i_byte_value,
    input  logic            i_last_byte,
    input  logic            i_no_byte,
    output usv_pkg::t_state o_state,
    output logic            o_valid_res
);
    import usv_pkg::*;

    t_state s_byte;
    t_state s_after;
    logic   second_ok;

    // range check for the first continuation byte
    always_comb begin
        case (i_state.rule)
            RULE_C2: second_ok = (i_byte_value >= BYTE_A0);
            RULE_E0: second_ok = (i_byte_value >= BYTE_A0);
            RULE_ED: second_ok = (i_byte_value <  BYTE_A0);
            RULE_F0: second_ok = (i_byte_value >= BYTE_90);
            RULE_F4: second_ok = (i_byte_value <  BYTE_90);
            default: second_ok = 1'b1;
        endcase
    end

    // decode one byte against the current state
    always_comb begin
        s_byte = i_state;
        if (i_state.pending != 2'd0) begin
            if (i_byte_value[7:6] != 2'b10 || !second_ok) begin
                s_byte = '{pending: 2'd0, rule: RULE_NONE, err: 1'b1};
            end else begin
                s_byte.pending = i_state.pending - 2'd1;
                s_byte.rule    = RULE_NONE;
            end
        end else if (!i_byte_value[7]) begin
            // ascii: controls and del are rejected
            if (i_byte_value < BYTE_SPACE || i_byte_value == BYTE_DEL) begin
                s_byte.err = 1'b1;
            end
        end else if (i_byte_value > BYTE_MAX || i_byte_value == BYTE_C0
                     || i_byte_value == BYTE_C1 || i_byte_value[7:6] == 2'b10) begin
            // bad lead or stray continuation byte
            s_byte = '{pending: 2'd0, rule: RULE_NONE, err: 1'b1};
        end else if (i_byte_value[7:5] == 3'b110) begin
            s_byte.pending = 2'd1;
            s_byte.rule    = (i_byte_value == BYTE_C2) ? RULE_C2 : RULE_NONE;
        end else if (i_byte_value[7:4] == 4'b1110) begin
            s_byte.pending = 2'd2;
            s_byte.rule    = (i_byte_value == BYTE_E0) ? RULE_E0 :
                             (i_byte_value == BYTE_ED) ? RULE_ED : RULE_NONE;
        end else begin
            s_byte.pending = 2'd3;
            s_byte.rule    = (i_byte_value == BYTE_F0) ? RULE_F0 :
                             (i_byte_value == BYTE_F4) ? RULE_F4 : RULE_NONE;
        end
    end

    // an item without a byte leaves the state alone
    assign s_after     = i_no_byte ? i_state : s_byte;
    assign o_valid_res = !s_after.err && (s_after.pending == 2'd0);
    assign o_state     = i_last_byte ? STATE_CLEAR : s_after;

endmodule

>>> sv/usv_checker.sv
// port-level checks for the utf-8 stream validator, bound to the top level
module usv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_valid_res
);
    logic [2:0] r_owed;
    logic       in_last_take;
    logic       out_take;

    assign in_last_take = i_in_valid && o_in_ready && i_last_byte;
    assign out_take     = o_out_valid && i_out_ready;

    // verdicts owed: final items taken minus verdicts delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= 3'd0;
        end else begin
            r_owed <= r_owed + {2'd0, in_last_take} - {2'd0, out_take};
        end
    end

    // no verdict without a final item behind it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take |-> r_owed != 3'd0)
        else $error("verdict delivered with none owed");

    // at most two strings in flight inside the block
    a_owed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed <= 3'd2)
        else $error("more final items taken than the block can hold");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_valid_res))
        else $error("stalled verdict changed");

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_last_byte (i_last_byte),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_valid_res (o_valid_res)
);
